### hdl/i2p_pkg.sv
// Shared types, constants and helper functions for the infix-to-postfix converter.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

	// Operator stack geometry
	localparam int STACK_DEPTH = 16;
	localparam int PTR_W       = $clog2(STACK_DEPTH);
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// Queue between classifier and sequencer
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Error codes
	localparam logic [2:0] ERR_OK              = 3'd0;
	localparam logic [2:0] ERR_OVERFLOW        = 3'd1;
	localparam logic [2:0] ERR_UNMATCHED_CLOSE = 3'd2;
	localparam logic [2:0] ERR_UNKNOWN         = 3'd3;
	localparam logic [2:0] ERR_UNMATCHED_OPEN  = 3'd4;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_POW   = 8'h5E;

	typedef enum logic [2:0] {
		CLS_ALNUM,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_OP,
		CLS_UNKNOWN
	} cls_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_has_char;
		logic [2:0] error_code;
		logic       run_end;
	} out_item_t;

	// Classified item passed from front to back
	typedef struct packed {
		cls_t       cls;
		logic [7:0] ch;
		logic       last;
	} cls_item_t;

	function automatic logic [1:0] prio(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
		if (c == CH_MUL || c == CH_DIV)    p = 2'd2;
		if (c == CH_POW)                   p = 2'd3;
		return p;
	endfunction

	function automatic cls_t classify(input logic [7:0] c);
		cls_t k;
		k = CLS_UNKNOWN;
		if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		    (c >= 8'h61 && c <= 8'h7A))
			k = CLS_ALNUM;
		else if (c == CH_OPEN)
			k = CLS_OPEN;
		else if (c == CH_CLOSE)
			k = CLS_CLOSE;
		else if (prio(c) != 2'd0)
			k = CLS_OP;
		return k;
	endfunction

endpackage

`default_nettype wire

### hdl/i2p_front.sv
// Front end: accepts input characters, classifies them and registers the result.
// Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire i2p_pkg::in_item_t   item,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output i2p_pkg::cls_item_t       push_data
);

	logic               valid_s1;
	i2p_pkg::cls_item_t item_s1;

	assign item_ready = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_data  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.cls  <= i2p_pkg::classify(item.in_char);
			item_s1.ch   <= item.in_char;
			item_s1.last <= item.in_last;
		end
	end

endmodule

`default_nettype wire

### hdl/i2p_queue.sv
// Short queue of classified items between the front end and the sequencer.
// Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push_valid,
	output logic                     push_ready,
	input  wire i2p_pkg::cls_item_t  push_data,
	output logic                     pop_valid,
	input  wire logic                pop_ready,
	output i2p_pkg::cls_item_t       pop_data
);

	i2p_pkg::cls_item_t              mem_q [i2p_pkg::QUEUE_DEPTH];
	logic [i2p_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [i2p_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [i2p_pkg::QCNT_W-1:0]      cnt_q;
	logic                            do_push;
	logic                            do_pop;

	assign push_ready = cnt_q != i2p_pkg::QCNT_W'(i2p_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

### hdl/i2p_back.sv
// Sequencer: owns the operator stack; at most one result per step goes via pend_q to out_q.
// Depends on i2p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2p_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire i2p_pkg::cls_item_t  q_data,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output i2p_pkg::out_item_t       result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_OP,
		ST_FLUSH,
		ST_FIN
	} state_t;

	state_t                          state_q, state_d;
	logic [7:0]                      stack_q [i2p_pkg::STACK_DEPTH];
	logic [i2p_pkg::CNT_W-1:0]       count_q;
	i2p_pkg::out_item_t              pend_q;
	logic                            pend_valid_q;
	i2p_pkg::out_item_t              out_q;
	logic                            out_valid_q;

	logic [i2p_pkg::PTR_W-1:0]       top_idx;
	logic [7:0]                      top;
	logic                            empty;
	logic                            full;
	state_t                          after;
	logic                            produce;
	i2p_pkg::out_item_t              prod;
	logic                            do_pop;
	logic                            do_push;
	logic                            move_out;
	logic                            out_free;
	logic                            adv;

	assign top_idx  = i2p_pkg::PTR_W'(count_q - 1'b1);
	assign top      = stack_q[top_idx];
	assign empty    = count_q == '0;
	assign full     = count_q == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH);
	assign after    = q_data.last ? ST_FLUSH : ST_FIN;
	assign out_free = !out_valid_q || result_ready;

	// A held result leaves for the output register when a newer one arrives or the item ends
	assign move_out = pend_valid_q && (produce || state_q == ST_FIN);
	assign adv      = !move_out || out_free;
	assign q_ready  = (state_q == ST_FIN) && adv;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_comb begin
		state_d = state_q;
		produce = 1'b0;
		prod    = '0;
		do_pop  = 1'b0;
		do_push = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_data.cls)
						i2p_pkg::CLS_ALNUM: begin
							produce           = 1'b1;
							prod.out_char     = q_data.ch;
							prod.out_has_char = 1'b1;
							state_d           = after;
						end
						i2p_pkg::CLS_OPEN: begin
							if (full) begin
								produce         = 1'b1;
								prod.error_code = i2p_pkg::ERR_OVERFLOW;
							end else begin
								do_push = 1'b1;
							end
							state_d = after;
						end
						i2p_pkg::CLS_CLOSE: state_d = ST_CLOSE;
						i2p_pkg::CLS_OP:    state_d = ST_OP;
						default: begin
							produce         = 1'b1;
							prod.error_code = i2p_pkg::ERR_UNKNOWN;
							state_d         = after;
						end
					endcase
				end
			end
			ST_CLOSE: begin
				if (empty) begin
					produce         = 1'b1;
					prod.error_code = i2p_pkg::ERR_UNMATCHED_CLOSE;
					state_d         = after;
				end else begin
					do_pop = 1'b1;
					if (top == i2p_pkg::CH_OPEN) begin
						state_d = after;
					end else begin
						produce           = 1'b1;
						prod.out_char     = top;
						prod.out_has_char = 1'b1;
					end
				end
			end
			ST_OP: begin
				if (!empty && i2p_pkg::prio(top) >= i2p_pkg::prio(q_data.ch)) begin
					do_pop            = 1'b1;
					produce           = 1'b1;
					prod.out_char     = top;
					prod.out_has_char = 1'b1;
				end else begin
					if (full) begin
						produce         = 1'b1;
						prod.error_code = i2p_pkg::ERR_OVERFLOW;
					end else begin
						do_push = 1'b1;
					end
					state_d = after;
				end
			end
			ST_FLUSH: begin
				if (empty) begin
					state_d = ST_FIN;
				end else begin
					do_pop  = 1'b1;
					produce = 1'b1;
					if (top == i2p_pkg::CH_OPEN) begin
						prod.error_code = i2p_pkg::ERR_UNMATCHED_OPEN;
					end else begin
						prod.out_char     = top;
						prod.out_has_char = 1'b1;
					end
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_q       <= '0;
			pend_valid_q <= 1'b0;
			out_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv && move_out) begin
				out_valid_q <= 1'b1;
				out_q       <= '{
					out_char:     pend_q.out_char,
					out_has_char: pend_q.out_has_char,
					error_code:   pend_q.error_code,
					run_end:      state_q == ST_FIN
				};
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				state_q <= state_d;
				if (produce) begin
					pend_q       <= prod;
					pend_valid_q <= 1'b1;
				end else if (state_q == ST_FIN) begin
					pend_valid_q <= 1'b0;
				end
				if (do_push)
					count_q <= count_q + 1'b1;
				else if (do_pop)
					count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && do_push) stack_q[count_q[i2p_pkg::PTR_W-1:0]] <= q_data.ch;
	end

endmodule

`default_nettype wire

### hdl/infix_to_postfix.sv
// Top level of the infix-to-postfix converter: front end, queue and sequencer.
// Depends on i2p_pkg, i2p_front, i2p_queue and i2p_back.
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one character a transfer,
//   with in_last marking the final character of an expression.
//   result channel (result_valid/result_ready/result) gives zero or more results
//   per character, the last of them marked by run_end.
// Path: a letter or digit passes through the front-end register, a queue entry and the
//   sequencer's holding register before it reaches the output register.
// Sequencing: the sequencer dispatches each character, then pops, pushes or emits
//   results one at a time, then closes out the character; for ')' it pops until a '('
//   is found, for an operator it pops while the top ranks at least as high and then
//   pushes, and the last character also flushes every entry left on the stack. A
//   two-entry queue lets the front end keep taking characters while the sequencer
//   works.
// Reset: arst_n clears the stack count, queue and all valid flags at once; the
//   stack contents are not cleared and no clearing pass is needed.
// Stall: when result_ready is low the output register holds, the sequencer holds
//   one more result internally and stops, then the queue fills and item_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module infix_to_postfix (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire i2p_pkg::in_item_t   item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output i2p_pkg::out_item_t       result
);

	logic               push_valid;
	logic               push_ready;
	i2p_pkg::cls_item_t push_data;
	logic               q_valid;
	logic               q_ready;
	i2p_pkg::cls_item_t q_data;

	i2p_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	i2p_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	i2p_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_ready      (q_ready),
		.q_data       (q_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

### hdl/i2p_checker.sv
// Port-level checks for infix_to_postfix, attached by the bind at the end of this file.
// Depends on i2p_pkg and infix_to_postfix.
`timescale 1ns / 1ps
`default_nettype none

module i2p_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	input  wire logic               item_ready,
	input  wire i2p_pkg::in_item_t  item,
	input  wire logic               result_valid,
	input  wire logic               result_ready,
	input  wire i2p_pkg::out_item_t result
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_char_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.out_has_char |-> result.error_code == i2p_pkg::ERR_OK)
		else $error("character result carries an error code");

	a_err_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.out_has_char |->
			result.out_char == 8'd0 && result.error_code != i2p_pkg::ERR_OK)
		else $error("empty result without error or with stray character");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.error_code <= i2p_pkg::ERR_UNMATCHED_OPEN)
		else $error("error code out of range");

	// Hold a stalled input transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input changed while stalled");

endmodule

bind infix_to_postfix i2p_checker u_i2p_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

### test/infix_to_postfix_test.sv
// Self-checking testbench for the infix-to-postfix converter.
// Needs only i2p_pkg and infix_to_postfix; a scoreboard class predicts every postfix result.
`timescale 1ns / 1ps

module infix_to_postfix_test;
	import i2p_pkg::*;

	localparam int ITEM_TARGET     = 470;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int TAIL_CYCLES     = 60;
	localparam int MAX_REPORTS     = 100;

	// Shunting-yard predictor and store of expected postfix results
	class postfix_scoreboard;
		logic [7:0] op_stack_m [STACK_DEPTH];
		int         stacked;
		out_item_t  expected_out[$];
		out_item_t  step_out[$];
		int         n_chars;
		int         n_results;
		int         n_error_results;
		int         n_fail;
		int         max_burst;

		function int op_rank(logic [7:0] c);
			case (c)
				CH_PLUS, CH_MINUS: return 1;
				CH_MUL, CH_DIV:    return 2;
				CH_POW:            return 3;
				default:           return 0;
			endcase
		endfunction

		function bit is_operand(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
				(c >= "a" && c <= "z");
		endfunction

		function void add_out(logic [7:0] c, bit has, logic [2:0] err);
			out_item_t r;
			if (step_out.size() >= STACK_DEPTH + 1)
				return;
			r.out_char     = has ? c : 8'h00;
			r.out_has_char = has;
			r.error_code   = err;
			r.run_end      = 1'b0;
			step_out.push_back(r);
		endfunction

		function void push_entry(logic [7:0] c);
			if (stacked >= STACK_DEPTH) begin
				add_out(8'h00, 1'b0, ERR_OVERFLOW);
			end else begin
				op_stack_m[stacked] = c;
				stacked++;
			end
		endfunction

		// Work out every result caused by one accepted character
		function void note_char(in_item_t it);
			logic [7:0] c;
			logic [7:0] top;
			bit         found;
			out_item_t  r;
			c = it.in_char;
			found = 1'b0;
			step_out.delete();
			n_chars++;
			if (is_operand(c)) begin
				add_out(c, 1'b1, ERR_OK);
			end else if (c == CH_OPEN) begin
				push_entry(c);
			end else if (c == CH_CLOSE) begin
				while (stacked > 0 && !found) begin
					stacked--;
					top = op_stack_m[stacked];
					if (top == CH_OPEN)
						found = 1'b1;
					else
						add_out(top, 1'b1, ERR_OK);
				end
				if (!found)
					add_out(8'h00, 1'b0, ERR_UNMATCHED_CLOSE);
			end else if (op_rank(c) != 0) begin
				// '(' ranks 0, so the pop stops there
				while (stacked > 0 && op_rank(op_stack_m[stacked - 1]) >= op_rank(c)) begin
					stacked--;
					add_out(op_stack_m[stacked], 1'b1, ERR_OK);
				end
				push_entry(c);
			end else begin
				add_out(8'h00, 1'b0, ERR_UNKNOWN);
			end
			if (it.in_last) begin
				while (stacked > 0) begin
					stacked--;
					top = op_stack_m[stacked];
					if (top == CH_OPEN)
						add_out(8'h00, 1'b0, ERR_UNMATCHED_OPEN);
					else
						add_out(top, 1'b1, ERR_OK);
				end
			end
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.run_end = 1'b1;
				step_out.push_back(r);
			end
			if (step_out.size() > max_burst)
				max_burst = step_out.size();
			foreach (step_out[i])
				expected_out.push_back(step_out[i]);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			n_results++;
			if (got.error_code != ERR_OK)
				n_error_results++;
			if (expected_out.size() == 0) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("%0t: unexpected result: got char=%02h has=%0d err=%0d end=%0d",
						$time, got.out_char, got.out_has_char, got.error_code, got.run_end);
				return;
			end
			want = expected_out.pop_front();
			if (got.out_char !== want.out_char || got.out_has_char !== want.out_has_char ||
			    got.error_code !== want.error_code || got.run_end !== want.run_end) begin
				n_fail++;
				if (n_fail <= MAX_REPORTS)
					$display("%0t: mismatch: expected char=%02h has=%0d err=%0d end=%0d,",
						$time, want.out_char, want.out_has_char, want.error_code,
						want.run_end, " got char=%02h has=%0d err=%0d end=%0d",
						got.out_char, got.out_has_char, got.error_code, got.run_end);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	in_item_t   item;
	logic       result_valid;
	logic       result_ready;
	out_item_t  result;

	postfix_scoreboard postfix_sb = new;

	logic [7:0] expr_buf[$];
	bit         seq_last;
	bit         stall_armed;
	bit         stall_done;
	bit         stall_over;
	int         burst_left;
	int         idle_cycles;

	infix_to_postfix i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int send_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 1) == 0)
			return 0;
		return gap_len();
	endfunction

	function automatic logic [7:0] operand_char();
		int k;
		k = $urandom_range(0, 61);
		if (k < 10)
			return 8'("0" + k);
		if (k < 36)
			return 8'("A" + k - 10);
		return 8'("a" + k - 36);
	endfunction

	function automatic logic [7:0] op_char();
		case ($urandom_range(0, 4))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_MUL;
			3:       return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 7))
			0:       return CH_OPEN;
			1:       return CH_CLOSE;
			2:       return op_char();
			3:       return operand_char();
			4:       return " ";
			5:       return "%";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Well-formed expression, optionally opened with a deep run of '('
	function automatic void build_expr(int max_ops, int max_nest, int start_nest);
		int  ops_left;
		int  nest;
		bit  need_operand;
		bit  done;
		expr_buf.delete();
		repeat (start_nest)
			expr_buf.push_back(CH_OPEN);
		nest = start_nest;
		ops_left = $urandom_range(0, max_ops);
		need_operand = 1'b1;
		done = 1'b0;
		while (!done) begin
			if (need_operand) begin
				if (nest < start_nest + max_nest && $urandom_range(0, 3) == 0) begin
					expr_buf.push_back(CH_OPEN);
					nest++;
				end else begin
					expr_buf.push_back(operand_char());
					need_operand = 1'b0;
				end
			end else if (nest > 0 && $urandom_range(0, 2) == 0) begin
				expr_buf.push_back(CH_CLOSE);
				nest--;
			end else if (ops_left > 0) begin
				expr_buf.push_back(op_char());
				ops_left--;
				need_operand = 1'b1;
			end else if (nest > 0) begin
				expr_buf.push_back(CH_CLOSE);
				nest--;
			end else begin
				done = 1'b1;
			end
		end
	endfunction

	function automatic void make_sequence();
		int kind;
		int pos;
		kind = $urandom_range(0, 99);
		seq_last = 1'b1;
		if (kind < 60) begin
			build_expr(6, $urandom_range(0, 3), 0);
		end else if (kind < 72) begin
			build_expr(4, 4, $urandom_range(10, 18));
		end else if (kind < 87) begin
			// corrupt one spot of an otherwise valid expression
			build_expr(6, $urandom_range(0, 3), 0);
			pos = $urandom_range(0, expr_buf.size() - 1);
			case ($urandom_range(0, 3))
				0:       expr_buf[pos] = 8'($urandom_range(0, 255));
				1:       expr_buf.insert(pos, CH_OPEN);
				2:       expr_buf.insert(pos, CH_CLOSE);
				default: if (expr_buf.size() > 1) expr_buf.delete(pos);
			endcase
			seq_last = ($urandom_range(0, 4) != 0);
		end else begin
			expr_buf.delete();
			repeat ($urandom_range(1, 6))
				expr_buf.push_back(noise_char());
			seq_last = 1'($urandom_range(0, 1));
		end
	endfunction

	// Valid stays high between back-to-back transfers; drop it only for a gap
	task automatic send_char(input logic [7:0] c, input logic last, input int gap);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{in_char: c, in_last: last};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		postfix_sb.note_char('{in_char: c, in_last: last});
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (postfix_sb.expected_out.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_directed();
		send_char(CH_CLOSE, 1'b0, 0);
		send_char(8'h00, 1'b0, 1);
		send_char(CH_OPEN, 1'b0, 0);
		send_char("a", 1'b0, 0);
		send_char(CH_MINUS, 1'b0, 2);
		send_char("b", 1'b0, 0);
		send_char(CH_CLOSE, 1'b0, 0);
		send_char(CH_POW, 1'b0, 0);
		send_char("c", 1'b0, 1);
		send_char(CH_MUL, 1'b0, 0);
		send_char("Z", 1'b0, 0);
		send_char(CH_DIV, 1'b0, 0);
		send_char(8'hFF, 1'b1, 3);
		drain_results();
		// fill the stack, overflow it, then flush the open parentheses
		repeat (STACK_DEPTH)
			send_char(CH_OPEN, 1'b0, $urandom_range(0, 2));
		send_char(CH_PLUS, 1'b1, 0);
	endtask

	initial begin : stimulus
		int next_drain;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain_results();
		next_drain = 120;
		while (postfix_sb.n_chars < ITEM_TARGET) begin
			if (!stall_armed && postfix_sb.n_chars >= 180) begin
				stall_armed = 1'b1;
				burst_left = 80;
			end
			// keep offering items while the receiver hold-off is pending or running
			if (postfix_sb.n_chars >= next_drain && (!stall_armed || stall_over)) begin
				drain_results();
				next_drain += $urandom_range(80, 140);
			end
			make_sequence();
			foreach (expr_buf[i])
				send_char(expr_buf[i], seq_last && (i == expr_buf.size() - 1), send_gap());
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Sent %0d characters and checked %0d results",
			postfix_sb.n_chars, postfix_sb.n_results,
			" (%0d error results, longest burst %0d).",
			postfix_sb.n_error_results, postfix_sb.max_burst);
		$display("Receiver hold-off of %0d cycles %s; %0d failures.", HOLD_OFF_CYCLES,
			stall_done ? "applied" : "not applied", postfix_sb.n_fail);
		if (postfix_sb.n_fail == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : receiver
		result_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_armed && !stall_done) begin
				// hold off long enough to back the block up to its input
				stall_done = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				stall_over = 1'b1;
			end else if ($urandom_range(0, 99) < 65) begin
				result_ready <= 1'b1;
				repeat ($urandom_range(0, 9) == 0 ? 100 : $urandom_range(1, 24)) @(posedge clk);
			end else begin
				result_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			postfix_sb.check_result(result);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

endmodule

### filelist.f
hdl/i2p_pkg.sv
hdl/i2p_front.sv
hdl/i2p_queue.sv
hdl/i2p_back.sv
hdl/infix_to_postfix.sv
hdl/i2p_checker.sv
test/infix_to_postfix_test.sv
